### hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at each rising edge, disabled while in reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/i2da_pkg.sv
// Package for the integer to decimal ASCII converter: widths, types, constants.
// No dependencies.
`timescale 1ns / 1ps

package i2da_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int BCD_W = 4 * NUM_DIGITS;
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int DIG_W = $clog2(NUM_DIGITS + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO = 8'd48;
	localparam logic [7:0] CHAR_NINE = 8'd57;

	typedef struct packed {
		logic                   neg;
		logic [VALUE_WIDTH-1:0] mag;
	} item_t;

	// Double-dabble correction: add 3 to every digit of 5 or more.
	function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
		logic [BCD_W-1:0] res;
		res = bcd;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (bcd[4*d +: 4] >= 4'd5)
				res[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
		end
		return res;
	endfunction

endpackage

### hdl/i2da_front.sv
// Front end: accepts values, applies sign mode, registers sign and magnitude.
// Depends on i2da_pkg.
`timescale 1ns / 1ps

module i2da_front import i2da_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        signed_mode,
	input  logic        push,
	output logic        full,
	input  logic [63:0] value_bits,
	output logic        q_push,
	output item_t       q_item,
	input  logic        q_full
);

	logic [VALUE_WIDTH-1:0] value;
	logic                   neg;
	logic                   valid_s1;
	item_t                  item_s1;

	assign value = value_bits[VALUE_WIDTH-1:0];
	assign neg = signed_mode & value[VALUE_WIDTH-1];

	assign q_push = valid_s1 & ~q_full;
	assign q_item = item_s1;
	assign full = valid_s1 & q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			item_s1.neg <= neg;
			item_s1.mag <= neg ? (~value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value;
		end
	end

endmodule

### hdl/i2da_queue.sv
// Short queue of classified items between front and back end.
// Depends on i2da_pkg.
`timescale 1ns / 1ps

module i2da_queue import i2da_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  item_t wr_item,
	output logic  q_full,
	input  logic  rd_en,
	output item_t rd_item,
	output logic  q_empty
);

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign q_full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr = wr_en & ~q_full;
	assign do_rd = rd_en & ~q_empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

### hdl/i2da_back.sv
// Back end: iterative binary to BCD conversion, leading-zero trim, character output.
// Depends on i2da_pkg.
`timescale 1ns / 1ps

module i2da_back import i2da_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  item_t      q_item,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] ascii_char,
	output logic       last_char
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_TRIM,
		ST_SIGN,
		ST_DIGS
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic                   neg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [DIG_W-1:0]       ndig_q;
	logic                   out_valid_q;
	logic [7:0]             char_q;
	logic                   last_q;
	logic                   slot_free;
	logic                   emit;
	logic [3:0]             top_digit;
	logic [BCD_W-1:0]       bcd_adj;

	assign slot_free = ~out_valid_q | pop;
	assign emit = slot_free & ((state_q == ST_SIGN) | (state_q == ST_DIGS));
	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign bcd_adj = bcd_adjust(bcd_q);
	assign q_pop = (state_q == ST_IDLE) & ~q_empty;
	assign empty = ~out_valid_q;
	assign ascii_char = char_q;
	assign last_char = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			bin_q <= '0;
			bcd_q <= '0;
			neg_q <= 1'b0;
			cnt_q <= '0;
			ndig_q <= '0;
			char_q <= '0;
			last_q <= 1'b0;
		end else begin
			out_valid_q <= emit | (out_valid_q & ~pop);
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						bin_q <= q_item.mag;
						neg_q <= q_item.neg;
						bcd_q <= '0;
						cnt_q <= CNT_W'(VALUE_WIDTH);
						ndig_q <= DIG_W'(NUM_DIGITS);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_WIDTH-1]};
					bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1))
						state_q <= ST_TRIM;
				end
				ST_TRIM: begin
					if (top_digit == 4'd0 && ndig_q != DIG_W'(1)) begin
						bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
						ndig_q <= ndig_q - 1'b1;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_DIGS;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						char_q <= CHAR_MINUS;
						last_q <= 1'b0;
						state_q <= ST_DIGS;
					end
				end
				ST_DIGS: begin
					if (slot_free) begin
						char_q <= CHAR_ZERO | {4'd0, top_digit};
						last_q <= (ndig_q == DIG_W'(1));
						bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
						ndig_q <= ndig_q - 1'b1;
						if (ndig_q == DIG_W'(1))
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hdl/integer_to_decimal_ascii.sv
// The back end takes one item at a time: its BCD shift loop converts one bit per cycle, the
// leading zero digits are trimmed, then characters go out one a cycle while the receiver pops.
// A two-entry queue and a front register let up to three items wait behind the converter.
// Reset (arst_n low, asynchronous): all queues empty, signed_mode = 1.
// Depends on i2da_pkg, i2da_front, i2da_queue, i2da_back, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module integer_to_decimal_ascii import i2da_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        push,
	output logic        full,
	input  logic [63:0] value_bits,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  ascii_char,
	output logic        last_char
);

	logic  signed_mode_q;
	logic  fq_push;
	item_t fq_item;
	logic  fq_full;
	logic  bq_pop;
	item_t bq_item;
	logic  bq_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			signed_mode_q <= 1'b1;
		else if (cfg_wr_en)
			signed_mode_q <= cfg_wr_data;
	end

	i2da_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.signed_mode (signed_mode_q),
		.push        (push),
		.full        (full),
		.value_bits  (value_bits),
		.q_push      (fq_push),
		.q_item      (fq_item),
		.q_full      (fq_full)
	);

	i2da_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_item (fq_item),
		.q_full  (fq_full),
		.rd_en   (bq_pop),
		.rd_item (bq_item),
		.q_empty (bq_empty)
	);

	i2da_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (bq_empty),
		.q_item     (bq_item),
		.q_pop      (bq_pop),
		.empty      (empty),
		.pop        (pop),
		.ascii_char (ascii_char),
		.last_char  (last_char)
	);

	`ASSERT_IMPL(a_char_legal, clk, arst_n, !empty, (ascii_char == CHAR_MINUS) || ((ascii_char >= CHAR_ZERO) && (ascii_char <= CHAR_NINE)), "illegal character on output")
	`ASSERT_IMPL(a_minus_not_last, clk, arst_n, !empty && (ascii_char == CHAR_MINUS), !last_char, "minus sign flagged as last")
	`ASSERT_NEXT(a_digit_after_minus, clk, arst_n, !empty && pop && (ascii_char == CHAR_MINUS), !empty, "no digit directly after minus sign")

endmodule

### test/integer_to_decimal_ascii_test.sv
// Testbench for integer_to_decimal_ascii: queued driver and monitor, decimal text predictor.
// Checks every character and last flag in both sign modes under varied handshake pressure.
// Depends on i2da_pkg and the integer_to_decimal_ascii RTL.
`timescale 1ns / 1ps

module integer_to_decimal_ascii_test;
	import i2da_pkg::*;

	localparam logic [63:0] WIDTH_MASK =
		(VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} glyph_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [63:0] value_bits = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  ascii_char;
	logic        last_char;

	logic [63:0] pending_values[$];
	glyph_t      text_due[$];
	logic        signed_now = 1'b1;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_start = 1'b0;
	int          hold_left = 0;
	int          mismatches = 0;

	integer_to_decimal_ascii uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.push(push),
		.full(full),
		.value_bits(value_bits),
		.empty(empty),
		.pop(pop),
		.ascii_char(ascii_char),
		.last_char(last_char)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void predict_text(input logic [63:0] raw);
		logic [63:0] mag;
		logic        neg;
		logic [3:0]  digs[20];
		int          n;
		mag = raw & WIDTH_MASK;
		neg = signed_now && mag[VALUE_WIDTH-1];
		if (neg) begin
			mag = (~mag + 64'd1) & WIDTH_MASK;
		end
		n = 0;
		do begin
			digs[n] = 4'(mag % 64'd10);
			mag = mag / 64'd10;
			n++;
		end while (mag != 64'd0);
		if (neg) begin
			text_due.push_back(glyph_t'{ch: CHAR_MINUS, last: 1'b0});
		end
		for (int i = n - 1; i >= 0; i--) begin
			text_due.push_back(glyph_t'{ch: CHAR_ZERO + 8'(digs[i]), last: (i == 0)});
		end
	endfunction

	function automatic logic [63:0] random_value();
		logic [63:0] r;
		int          k;
		r = {$urandom, $urandom};
		k = $urandom_range(0, 9);
		if (k == 0) begin
			case ($urandom_range(0, 5))
				0: r = 64'd0;
				1: r = '1;
				2: r = 64'h8000_0000_0000_0000;
				3: r = 64'h7FFF_FFFF_FFFF_FFFF;
				4: r = 64'd10000000000000000000;
				default: r = 64'd9999999999999999999;
			endcase
		end else if (k < 4) begin
			r = r >> $urandom_range(0, 63);
		end else if (k < 6) begin
			r = -(r >> $urandom_range(1, 63));
		end
		return r;
	endfunction

	// driver: one transaction offered at a time, held while full
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && full) begin
			push <= 1'b1;
		end else begin
			if (push) begin
				predict_text(value_bits);
				void'(pending_values.pop_front());
			end
			if (pending_values.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				push <= 1'b1;
				value_bits <= pending_values[0];
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_start) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		glyph_t due;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (text_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected character, expected none, actual %h last %b",
						$time, ascii_char, last_char);
				end else begin
					due = text_due.pop_front();
					if (ascii_char !== due.ch) begin
						mismatches++;
						$display("%0t: ascii_char expected %h actual %h",
							$time, due.ch, ascii_char);
					end
					if (last_char !== due.last) begin
						mismatches++;
						$display("%0t: last_char expected %b actual %b",
							$time, due.last, last_char);
					end
				end
			end
			pop <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic drain();
		while (pending_values.size() != 0 || push || text_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		signed_now = m;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic queue_random(input int n);
		@(negedge clk);
		repeat (n) pending_values.push_back(random_value());
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// signed mode from reset
		pending_values.push_back(64'd0);
		pending_values.push_back(64'd1);
		pending_values.push_back('1);
		pending_values.push_back(64'd9);
		pending_values.push_back(64'd10);
		pending_values.push_back(-64'd9);
		pending_values.push_back(-64'd10);
		pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
		pending_values.push_back(64'h8000_0000_0000_0000);
		pending_values.push_back(-64'd1000000000000000000);
		pending_values.push_back(64'd1000000000000000000);
		pending_values.push_back(64'h5555_5555_5555_5555);
		pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
		drain();

		write_mode(1'b0);
		pending_values.push_back(64'd0);
		pending_values.push_back('1);
		pending_values.push_back(64'd10000000000000000000);
		pending_values.push_back(64'd9999999999999999999);
		pending_values.push_back(64'h8000_0000_0000_0000);
		pending_values.push_back(64'd1);
		pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
		pending_values.push_back(64'd999999999999999999);
		drain();

		// receiver held off long enough for the input side to back up
		write_mode(1'b1);
		set_idling(0, 0);
		queue_random(30);
		hold_start = 1'b1;
		@(negedge clk);
		hold_start = 1'b0;
		drain();

		for (int p = 0; p < 8; p++) begin
			write_mode(p >= 4);
			case (p % 4)
				0: set_idling(0, 0);
				1: set_idling(83, 0);
				2: set_idling(0, 83);
				default: set_idling(17, 17);
			endcase
			if (p == 3) begin
				queue_random(25);
				drain();
				queue_random(26);
			end else begin
				queue_random(51);
			end
			drain();
		end

		repeat (100) @(negedge clk);
		if (text_due.size() != 0) begin
			mismatches++;
			$display("%0t: %0d characters expected, none arrived", $time, text_due.size());
		end
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/i2da_pkg.sv
hdl/i2da_front.sv
hdl/i2da_queue.sv
hdl/i2da_back.sv
hdl/integer_to_decimal_ascii.sv
test/integer_to_decimal_ascii_test.sv
